[rtl/core/strip_cluster_profile_accumulator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the strip cluster profile accumulator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STRIP_CLUSTER_PROFILE_ACCUMULATOR_DEFINES_SVH
`define STRIP_CLUSTER_PROFILE_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SCPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define SCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/scpa_pkg.sv]
// ----------------------------------------------------------------------------
// scpa_pkg
// Field widths, action and register codes for the profile accumulator.
// ----------------------------------------------------------------------------
package scpa_pkg;

    localparam int ADC_W   = 10;
    localparam int STRIP_W = 10;
    localparam int TIME_W  = 10;
    localparam int OFF_W   = 5;
    localparam int SUM_W   = 32;
    localparam int ADDED_W = 10;
    localparam int DIFF_W  = STRIP_W + 1;

    // Action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_END  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_THR   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_THR = 2'd1;

    localparam logic [ADC_W-1:0]   PEAK_THR_RST   = 10'd60;
    localparam logic [ADC_W-1:0]   SAMPLE_THR_RST = 10'd10;
    localparam logic [ADDED_W-1:0] ADDED_MAX      = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX        = '1;

    typedef struct packed {
        logic [STRIP_W-1:0] strip;
        logic [TIME_W-1:0]  time_bin;
        logic [ADC_W-1:0]   adc;
    } sample_t;

endpackage

[rtl/core/strip_cluster_profile_accumulator.sv]
// ----------------------------------------------------------------------------
// strip_cluster_profile_accumulator
// Collects event samples, finds the peak and builds a strip offset profile.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. action selects load sample, end of event or read histogram bin.
//   Load items are taken one per cycle while idle and never raise busy; they
//   return no result. A load beyond MAX_SAMPLES stored samples is dropped and
//   flagged. End of event with no sample, or with a peak at or below
//   peak_threshold, answers in the cycle after it is taken. An accepted event
//   walks the sample store through a three-stage read / histogram
//   read-modify-write pipeline, one sample per cycle, set by the single read
//   port of the sample store; the result is given once the last sample has
//   left the pipeline and any bin write for it is made. A read item's bin is
//   read as the item is taken; the read state then registers the result.
//   Each result shows on the result ports for one cycle with done high; the
//   receiver cannot stall it. Configuration writes (cfg_write, cfg_addr,
//   cfg_data) take effect at once; issue them only while idle.
//   Reset clears thresholds to 60 / 10, the event state, the event counter and
//   the histogram valid bits (every bin reads zero). No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "strip_cluster_profile_accumulator_defines.svh"

module strip_cluster_profile_accumulator
    import scpa_pkg::*;
#(
    parameter int MAX_SAMPLES = 512,
    parameter int HALF_WINDOW = 15
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [STRIP_W-1:0]    strip,
    input  logic [TIME_W-1:0]     time_bin,
    input  logic [ADC_W-1:0]      adc,
    input  logic signed [OFF_W-1:0] bin_offset,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ADC_W-1:0]      cfg_data,
    output logic                  done,
    output logic                  accepted,
    output logic [ADC_W-1:0]      peak_adc,
    output logic [STRIP_W-1:0]    peak_strip,
    output logic [TIME_W-1:0]     peak_time_bin,
    output logic [ADDED_W-1:0]    added_count,
    output logic                  overflow,
    output logic [SUM_W-1:0]      event_count,
    output logic [SUM_W-1:0]      bin_sum
);

    localparam int NUM_BINS = 2 * HALF_WINDOW + 1;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int IDX_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);
    localparam logic signed [DIFF_W-1:0] HW_S = DIFF_W'(HALF_WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    // Memories
    sample_t            samp_mem [MAX_SAMPLES];
    logic [SUM_W-1:0]   hist_mem [NUM_BINS];
    logic [NUM_BINS-1:0] hist_valid_reg;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   walk_reg, walk_next;
    logic [ADC_W-1:0]   pk_adc_reg, pk_adc_next;
    logic [STRIP_W-1:0] pk_strip_reg, pk_strip_next;
    logic [TIME_W-1:0]  pk_time_reg, pk_time_next;
    logic               drop_reg, drop_next;
    logic [SUM_W-1:0]   events_reg, events_next;
    logic [ADDED_W-1:0] added_reg, added_next;
    logic [ADC_W-1:0]   pthr_reg, sthr_reg;

    // Pipeline
    logic               s_vld_reg, s_vld_next;
    sample_t            samp_rd_reg;
    logic               h_vld_reg;
    logic [BIN_W-1:0]   h_addr_reg;
    logic [ADC_W-1:0]   h_adc_reg;
    logic               h_bv_reg;
    logic [SUM_W-1:0]   hist_rd_reg;
    logic               w_vld_reg;
    logic [BIN_W-1:0]   w_addr_reg;
    logic [SUM_W-1:0]   w_data_reg;
    logic               rd_inwin_reg;

    // Result registers
    logic               done_reg, done_next;
    logic               res_acc_next;
    logic [ADC_W-1:0]   res_adc_next;
    logic [STRIP_W-1:0] res_strip_next;
    logic [TIME_W-1:0]  res_time_next;
    logic [ADDED_W-1:0] res_added_next;
    logic               res_ovf_next;
    logic [SUM_W-1:0]   res_events_next;
    logic [SUM_W-1:0]   res_sum_next;
    logic               accepted_reg;
    logic [ADC_W-1:0]   peak_adc_reg;
    logic [STRIP_W-1:0] peak_strip_reg;
    logic [TIME_W-1:0]  peak_time_reg;
    logic [ADDED_W-1:0] added_out_reg;
    logic               overflow_reg;
    logic [SUM_W-1:0]   event_count_reg;
    logic [SUM_W-1:0]   bin_sum_reg;

    logic               take;
    logic               samp_we;
    logic               issue;
    logic               hit1;
    logic signed [DIFF_W-1:0] diff1;
    logic [BIN_W-1:0]   bin1;
    logic signed [DIFF_W-1:0] rd_off;
    logic               rd_inwin;
    logic [BIN_W-1:0]   rd_bin;
    logic [BIN_W-1:0]   hist_raddr;
    logic [SUM_W-1:0]   old_sum;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   new_sum;

    assign busy = (state_reg != ST_IDLE);
    assign take = start && !busy;
    assign issue = (walk_reg != count_reg);

    // Stage 1: sample from the store, qualify against the peak
    assign diff1 = $signed({1'b0, samp_rd_reg.strip}) - $signed({1'b0, pk_strip_reg});
    assign hit1  = s_vld_reg && (samp_rd_reg.time_bin == pk_time_reg)
                   && (samp_rd_reg.adc > sthr_reg)
                   && (diff1 >= -HW_S) && (diff1 <= HW_S);
    assign bin1  = BIN_W'(diff1 + HW_S);

    // Read command: map the signed offset onto a bin address
    assign rd_off   = DIFF_W'(bin_offset);
    assign rd_inwin = (rd_off >= -HW_S) && (rd_off <= HW_S);
    assign rd_bin   = BIN_W'(rd_off + HW_S);
    assign hist_raddr = (state_reg == ST_WALK) ? bin1 : rd_bin;

    // Stage 2: forward the bin written last cycle, then saturate
    always_comb
    begin
        if (w_vld_reg && (w_addr_reg == h_addr_reg))
        begin
            old_sum = w_data_reg;
        end
        else if (h_bv_reg)
        begin
            old_sum = hist_rd_reg;
        end
        else
        begin
            old_sum = '0;
        end
        sum_wide = {1'b0, old_sum} + (SUM_W + 1)'(h_adc_reg);
        new_sum  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    // Control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        pk_adc_next     = pk_adc_reg;
        pk_strip_next   = pk_strip_reg;
        pk_time_next    = pk_time_reg;
        drop_next       = drop_reg;
        events_next     = events_reg;
        added_next      = added_reg;
        s_vld_next      = 1'b0;
        samp_we         = 1'b0;
        done_next       = 1'b0;
        res_acc_next    = 1'b0;
        res_adc_next    = '0;
        res_strip_next  = '0;
        res_time_next   = '0;
        res_added_next  = '0;
        res_ovf_next    = 1'b0;
        res_events_next = events_reg;
        res_sum_next    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            if (count_reg >= CNT_FULL)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                samp_we = 1'b1;
                                if ((count_reg == '0) || (adc > pk_adc_reg))
                                begin
                                    pk_adc_next   = adc;
                                    pk_strip_next = strip;
                                    pk_time_next  = time_bin;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_END:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                drop_next = 1'b0;
                            end
                            else
                            begin
                                events_next = events_reg + 1'b1;
                                if (pk_adc_reg > pthr_reg)
                                begin
                                    // hold the event state until the walk ends
                                    state_next = ST_WALK;
                                    walk_next  = '0;
                                    added_next = '0;
                                end
                                else
                                begin
                                    done_next       = 1'b1;
                                    res_adc_next    = pk_adc_reg;
                                    res_strip_next  = pk_strip_reg;
                                    res_time_next   = pk_time_reg;
                                    res_ovf_next    = drop_reg;
                                    res_events_next = events_next;
                                    count_next      = '0;
                                    pk_adc_next     = '0;
                                    pk_strip_next   = '0;
                                    pk_time_next    = '0;
                                    drop_next       = 1'b0;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            // unused action: drop the item
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next    = 1'b1;
                res_sum_next = (rd_inwin_reg && h_bv_reg) ? hist_rd_reg : '0;
                state_next   = ST_IDLE;
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    walk_next  = walk_reg + 1'b1;
                    s_vld_next = 1'b1;
                end
                if (h_vld_reg && (added_reg != ADDED_MAX))
                begin
                    added_next = added_reg + 1'b1;
                end
                if (!issue && !s_vld_reg && !h_vld_reg)
                begin
                    done_next      = 1'b1;
                    res_acc_next   = 1'b1;
                    res_adc_next   = pk_adc_reg;
                    res_strip_next = pk_strip_reg;
                    res_time_next  = pk_time_reg;
                    res_added_next = added_reg;
                    res_ovf_next   = drop_reg;
                    count_next     = '0;
                    pk_adc_next    = '0;
                    pk_strip_next  = '0;
                    pk_time_next   = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            walk_reg       <= '0;
            pk_adc_reg     <= '0;
            pk_strip_reg   <= '0;
            pk_time_reg    <= '0;
            drop_reg       <= 1'b0;
            events_reg     <= '0;
            added_reg      <= '0;
            pthr_reg       <= PEAK_THR_RST;
            sthr_reg       <= SAMPLE_THR_RST;
            s_vld_reg      <= 1'b0;
            h_vld_reg      <= 1'b0;
            w_vld_reg      <= 1'b0;
            hist_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            walk_reg     <= walk_next;
            pk_adc_reg   <= pk_adc_next;
            pk_strip_reg <= pk_strip_next;
            pk_time_reg  <= pk_time_next;
            drop_reg     <= drop_next;
            events_reg   <= events_next;
            added_reg    <= added_next;
            s_vld_reg    <= s_vld_next;
            h_vld_reg    <= hit1;
            w_vld_reg    <= h_vld_reg;
            done_reg     <= done_next;
            if (h_vld_reg)
            begin
                hist_valid_reg[h_addr_reg] <= 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_addr)
                    REG_PEAK_THR:   pthr_reg <= cfg_data;
                    REG_SAMPLE_THR: sthr_reg <= cfg_data;
                    default:
                    begin
                        // index beyond the register list: ignore
                    end
                endcase
            end
        end
    end

    // Sample store: write on load, read by the walk index
    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            samp_mem[count_reg[IDX_W-1:0]] <= '{strip: strip, time_bin: time_bin, adc: adc};
        end
        samp_rd_reg <= samp_mem[walk_reg[IDX_W-1:0]];
    end

    // Histogram: read for stage 2 or a read item, write back from stage 2
    always_ff @(posedge clk)
    begin
        hist_rd_reg  <= hist_mem[hist_raddr];
        h_bv_reg     <= hist_valid_reg[hist_raddr];
        h_addr_reg   <= bin1;
        h_adc_reg    <= samp_rd_reg.adc;
        rd_inwin_reg <= rd_inwin;
        w_addr_reg   <= h_addr_reg;
        w_data_reg   <= new_sum;
        if (h_vld_reg)
        begin
            hist_mem[h_addr_reg] <= new_sum;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            accepted_reg    <= res_acc_next;
            peak_adc_reg    <= res_adc_next;
            peak_strip_reg  <= res_strip_next;
            peak_time_reg   <= res_time_next;
            added_out_reg   <= res_added_next;
            overflow_reg    <= res_ovf_next;
            event_count_reg <= res_events_next;
            bin_sum_reg     <= res_sum_next;
        end
    end

    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign peak_adc      = peak_adc_reg;
    assign peak_strip    = peak_strip_reg;
    assign peak_time_bin = peak_time_reg;
    assign added_count   = added_out_reg;
    assign overflow      = overflow_reg;
    assign event_count   = event_count_reg;
    assign bin_sum       = bin_sum_reg;

    // Assertions
    `SCPA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL, "sample count past store depth")
    `SCPA_ASSERT_NEXT(a_write_holds_walk, clk, rst_n, h_vld_reg, state_reg == ST_WALK, "walk ended with a write pending")
    `SCPA_ASSERT_NEXT(a_read_answers, clk, rst_n, state_reg == ST_READ, done_reg, "read item gave no result")
    `SCPA_ASSERT_NOW(a_reject_adds_none, clk, rst_n, done_reg && !accepted, added_count == '0, "rejected event added samples")

endmodule

[verif/tb_strip_cluster_profile_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for strip_cluster_profile_accumulator
// Sends load, end-of-event, read and unused items through the start/busy
// command port. A built-in predictor works out each result, or a typed script
// row gives it; results are checked field by field as done pulses. A directed
// script comes first, then randomized events under several threshold settings,
// including one event that overfills the sample store.
// ----------------------------------------------------------------------------
module tb_strip_cluster_profile_accumulator;
    import scpa_pkg::*;

    localparam int STORE_DEPTH = 512;
    localparam int WINDOW      = 15;
    localparam int NUM_BINS    = 2 * WINDOW + 1;

    // Codes the package leaves out: the spare action and the spare register slots
    localparam logic [1:0]            ACT_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               accepted;
        logic [ADC_W-1:0]   peak_adc;
        logic [STRIP_W-1:0] peak_strip;
        logic [TIME_W-1:0]  peak_time_bin;
        logic [ADDED_W-1:0] added_count;
        logic               overflow;
        logic [SUM_W-1:0]   event_count;
        logic [SUM_W-1:0]   bin_sum;
    } result_t;

    // One row of the directed script; want is used only where typed is set
    typedef struct packed {
        logic [1:0]         act;
        logic [STRIP_W-1:0] strip;
        logic [TIME_W-1:0]  tbin;
        logic [ADC_W-1:0]   adc;
        logic [OFF_W-1:0]   boff;
        logic               typed;
        result_t            want;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            action;
    logic [STRIP_W-1:0]    strip;
    logic [TIME_W-1:0]     time_bin;
    logic [ADC_W-1:0]      adc;
    logic signed [OFF_W-1:0] bin_offset;
    logic                  cfg_write;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [ADC_W-1:0]      cfg_data;
    logic                  done;
    logic                  accepted;
    logic [ADC_W-1:0]      peak_adc;
    logic [STRIP_W-1:0]    peak_strip;
    logic [TIME_W-1:0]     peak_time_bin;
    logic [ADDED_W-1:0]    added_count;
    logic                  overflow;
    logic [SUM_W-1:0]      event_count;
    logic [SUM_W-1:0]      bin_sum;

    strip_cluster_profile_accumulator #(
        .MAX_SAMPLES (STORE_DEPTH),
        .HALF_WINDOW (WINDOW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .strip         (strip),
        .time_bin      (time_bin),
        .adc           (adc),
        .bin_offset    (bin_offset),
        .cfg_write     (cfg_write),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .done          (done),
        .accepted      (accepted),
        .peak_adc      (peak_adc),
        .peak_strip    (peak_strip),
        .peak_time_bin (peak_time_bin),
        .added_count   (added_count),
        .overflow      (overflow),
        .event_count   (event_count),
        .bin_sum       (bin_sum)
    );

    // ------------------------------------------------------------------------
    // Predictor state: thresholds, the event's sample store, running peak,
    // drop flag, the offset histogram and the event counter.
    // ------------------------------------------------------------------------
    logic [ADC_W-1:0]   peak_thr;
    logic [ADC_W-1:0]   sample_thr;
    logic [STRIP_W-1:0] held_strip [STORE_DEPTH];
    logic [TIME_W-1:0]  held_time  [STORE_DEPTH];
    logic [ADC_W-1:0]   held_adc   [STORE_DEPTH];
    int                 held_count;
    logic [ADC_W-1:0]   lead_adc;
    logic [STRIP_W-1:0] lead_strip;
    logic [TIME_W-1:0]  lead_time;
    logic               store_spilled;
    logic [SUM_W-1:0]   profile [NUM_BINS];
    logic [SUM_W-1:0]   events_total;

    // Results still owed by the block, oldest first
    result_t owed_results [$];

    int  errors;
    int  sent_items;
    bit  steady;   // set to hold start high with no gaps

    // ------------------------------------------------------------------------
    // Directed script. Typed rows carry results that follow directly from the
    // reset state or the extremes; the rest go through the predictor.
    // ------------------------------------------------------------------------
    localparam int SCRIPT_LEN = 27;
    step_t script [SCRIPT_LEN] = '{
        // read and empty end of event straight out of reset: all zero
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    5'd0,   1'b1, '0},
        '{ACT_END,    10'd0,    10'd0,    10'd0,    5'd0,   1'b1, '0},
        // spare action with every field at its top: ignored, no result
        '{ACT_UNUSED, 10'd1023, 10'd1023, 10'd1023, 5'd31,  1'b0, '0},
        // first sample always leads, then a full-scale sample takes over;
        // an equal ADC later does not move the peak
        '{ACT_LOAD,   10'd0,    10'd0,    10'd0,    5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd1023, 10'd1023, 10'd1023, 5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd1020, 10'd1023, 10'd1023, 5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd1010, 10'd1023, 10'd500,  5'd0,   1'b0, '0},
        // offset -15 with ADC just above the sample threshold: counted
        '{ACT_LOAD,   10'd1008, 10'd1023, 10'd11,   5'd0,   1'b0, '0},
        // offset -16: outside the window
        '{ACT_LOAD,   10'd1007, 10'd1023, 10'd900,  5'd0,   1'b0, '0},
        // ADC equal to the sample threshold: skipped
        '{ACT_LOAD,   10'd1015, 10'd1023, 10'd10,   5'd0,   1'b0, '0},
        // other time bin: skipped
        '{ACT_LOAD,   10'd1022, 10'd1022, 10'd800,  5'd0,   1'b0, '0},
        '{ACT_END,    10'd0,    10'd0,    10'd0,    5'd0,   1'b1,
          '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd4, 1'b0, 32'd1, 32'd0}},
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    5'd0,   1'b1,
          '{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 32'd1, 32'd1023}},
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    -5'sd15, 1'b1,
          '{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 32'd1, 32'd11}},
        // read at -16 lies outside the window: zero
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    -5'sd16, 1'b1,
          '{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 32'd1, 32'd0}},
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    5'd15,  1'b1,
          '{1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 32'd1, 32'd0}},
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    -5'sd3, 1'b0, '0},
        // peak equal to the peak threshold: rejected
        '{ACT_LOAD,   10'd5,    10'd7,    10'd60,   5'd0,   1'b0, '0},
        '{ACT_END,    10'd0,    10'd0,    10'd0,    5'd0,   1'b1,
          '{1'b0, 10'd60, 10'd5, 10'd7, 10'd0, 1'b0, 32'd2, 32'd0}},
        // peak at strip 0: offset +15 counted, +16 dropped
        '{ACT_LOAD,   10'd0,    10'd512,  10'd700,  5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd15,   10'd512,  10'd699,  5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd16,   10'd512,  10'd699,  5'd0,   1'b0, '0},
        '{ACT_LOAD,   10'd3,    10'd512,  10'd700,  5'd0,   1'b0, '0},
        '{ACT_END,    10'd0,    10'd0,    10'd0,    5'd0,   1'b0, '0},
        '{ACT_READ,   10'd0,    10'd0,    10'd0,    5'd15,  1'b0, '0},
        // lone zero sample still leads; rejected
        '{ACT_LOAD,   10'd9,    10'd9,    10'd0,    5'd0,   1'b0, '0},
        '{ACT_END,    10'd0,    10'd0,    10'd0,    5'd0,   1'b1,
          '{1'b0, 10'd0, 10'd9, 10'd9, 10'd0, 1'b0, 32'd4, 32'd0}}
    };

    // ------------------------------------------------------------------------
    // Predict one item: update the model state and return the result, if any.
    // ------------------------------------------------------------------------
    function automatic void profile_predict(
        input  logic [1:0]         act,
        input  logic [STRIP_W-1:0] s,
        input  logic [TIME_W-1:0]  t,
        input  logic [ADC_W-1:0]   a,
        input  logic [OFF_W-1:0]   boff,
        output bit                 gives,
        output result_t            r
    );
        int              off;
        int              d;
        logic [SUM_W:0]  wide;
        logic [ADDED_W-1:0] added;
        logic            take;
        r     = '0;
        gives = 1'b0;
        case (act)
            ACT_LOAD:
            begin
                // a full store drops the sample and only flags it
                if (held_count >= STORE_DEPTH)
                    store_spilled = 1'b1;
                else
                begin
                    held_strip[held_count] = s;
                    held_time[held_count]  = t;
                    held_adc[held_count]   = a;
                    if (held_count == 0 || a > lead_adc)
                    begin
                        lead_adc   = a;
                        lead_strip = s;
                        lead_time  = t;
                    end
                    held_count++;
                end
            end
            ACT_READ:
            begin
                gives = 1'b1;
                off   = $signed(boff);
                if (off >= -WINDOW && off <= WINDOW)
                    r.bin_sum = profile[off + WINDOW];
                r.event_count = events_total;
            end
            ACT_END:
            begin
                gives = 1'b1;
                if (held_count > 0)
                begin
                    events_total++;
                    take  = lead_adc > peak_thr;
                    added = '0;
                    if (take)
                    begin
                        for (int i = 0; i < held_count; i++)
                        begin
                            if (held_time[i] != lead_time || held_adc[i] <= sample_thr)
                                continue;
                            d = int'(held_strip[i]) - int'(lead_strip);
                            if (d < -WINDOW || d > WINDOW)
                                continue;
                            // saturate the bin at all ones
                            wide = {1'b0, profile[d + WINDOW]} + held_adc[i];
                            profile[d + WINDOW] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
                            if (added != ADDED_MAX)
                                added++;
                        end
                    end
                    r.accepted      = take;
                    r.peak_adc      = lead_adc;
                    r.peak_strip    = lead_strip;
                    r.peak_time_bin = lead_time;
                    r.added_count   = added;
                    r.overflow      = store_spilled;
                end
                r.event_count = events_total;
                held_count    = 0;
                lead_adc      = '0;
                lead_strip    = '0;
                lead_time     = '0;
                store_spilled = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock and the fixed time limit
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result check: every done pulse must match the oldest owed result.
    // ------------------------------------------------------------------------
    result_t seen;
    result_t owed;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen = {accepted, peak_adc, peak_strip, peak_time_bin,
                    added_count, overflow, event_count, bin_sum};
            if (owed_results.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result at %0t: %p", $realtime, seen);
                errors++;
            end
            else
            begin
                owed = owed_results.pop_front();
                if (seen.accepted !== owed.accepted || seen.peak_adc !== owed.peak_adc ||
                    seen.peak_strip !== owed.peak_strip ||
                    seen.peak_time_bin !== owed.peak_time_bin ||
                    seen.added_count !== owed.added_count ||
                    seen.overflow !== owed.overflow ||
                    seen.event_count !== owed.event_count ||
                    seen.bin_sum !== owed.bin_sum)
                begin
                    if (errors < 10)
                        $display("mismatch at %0t\n  expected %p\n  actual   %p",
                                 $realtime, owed, seen);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item driver: idle at random unless steady, present the item at the
    // falling edge, hold it until taken, then log what the block owes.
    // ------------------------------------------------------------------------
    task automatic issue_item(
        input logic [1:0]         act,
        input logic [STRIP_W-1:0] s,
        input logic [TIME_W-1:0]  t,
        input logic [ADC_W-1:0]   a,
        input logic [OFF_W-1:0]   boff,
        input logic               typed,
        input result_t            want
    );
        bit      gives;
        result_t predicted;
        @(negedge clk);
        if (!steady)
        begin
            while ($urandom_range(99) < 32)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start      <= 1'b1;
        action     <= act;
        strip      <= s;
        time_bin   <= t;
        adc        <= a;
        bin_offset <= boff;
        // hold until an edge with busy low takes the item
        @(posedge clk);
        while (busy)
            @(posedge clk);
        profile_predict(act, s, t, a, boff, gives, predicted);
        if (gives)
            owed_results = {owed_results, (typed ? want : predicted)};
        if (act != ACT_UNUSED)
            sent_items++;
    endtask

    // Item of the given action with every payload field drawn at random
    task automatic issue_noise(input logic [1:0] act);
        issue_item(act, STRIP_W'($urandom_range(1023)), TIME_W'($urandom_range(1023)),
                   ADC_W'($urandom_range(1023)), OFF_W'($urandom_range(31)), 1'b0, '0);
    endtask

    // Drop start and hold off until the block owes nothing, then let the block
    // sit idle before returning.
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [ADC_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PEAK_THR:   peak_thr   = value;
            REG_SAMPLE_THR: sample_thr = value;
            default: ;
        endcase
    endtask

    // ADC values clustered around both thresholds half of the time
    function automatic logic [ADC_W-1:0] pick_adc();
        case ($urandom_range(3))
            0:       return ADC_W'(sample_thr + $urandom_range(4) - 2);
            1:       return ADC_W'(peak_thr + $urandom_range(4) - 2);
            default: return ADC_W'($urandom_range(1023));
        endcase
    endfunction

    // One well-formed event: samples mostly in one time bin around one strip
    task automatic shaped_event(input int n_samples);
        logic [TIME_W-1:0]  tc;
        logic [STRIP_W-1:0] sc;
        tc = TIME_W'($urandom_range(1023));
        sc = STRIP_W'($urandom_range(1023));
        repeat (n_samples)
        begin
            issue_item(ACT_LOAD, STRIP_W'(sc + $urandom_range(40) - 20),
                       ($urandom_range(3) == 0) ? TIME_W'($urandom_range(1023)) : tc,
                       pick_adc(), OFF_W'($urandom_range(31)), 1'b0, '0);
        end
        issue_noise(ACT_END);
    endtask

    // Random traffic, mostly whole events followed by reads, plus noise
    task automatic random_traffic(input int quota);
        int stop_at;
        int pick;
        stop_at = sent_items + quota;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                shaped_event($urandom_range(1, 12));
                repeat ($urandom_range(2))
                    issue_noise(ACT_READ);
            end
            else
            begin
                if (pick < 80)
                    issue_noise(ACT_READ);
                else if (pick < 88)
                    // stray sample; it joins the next event
                    issue_noise(ACT_LOAD);
                else if (pick < 94)
                    // often an empty event
                    issue_noise(ACT_END);
                else
                    issue_noise(ACT_UNUSED);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_LOAD;
        strip      = '0;
        time_bin   = '0;
        adc        = '0;
        bin_offset = '0;
        cfg_write  = 1'b0;
        cfg_addr   = REG_PEAK_THR;
        cfg_data   = '0;
        errors     = 0;
        sent_items = 0;
        steady     = 1'b0;

        // model reset state
        peak_thr      = PEAK_THR_RST;
        sample_thr    = SAMPLE_THR_RST;
        held_count    = 0;
        lead_adc      = '0;
        lead_strip    = '0;
        lead_time     = '0;
        store_spilled = 1'b0;
        events_total  = '0;
        for (int i = 0; i < NUM_BINS; i++)
            profile[i] = '0;

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed script under the reset thresholds
        for (int i = 0; i < SCRIPT_LEN; i++)
            issue_item(script[i].act, script[i].strip, script[i].tbin, script[i].adc,
                       script[i].boff, script[i].typed, script[i].want);

        // both thresholds at zero; spare slots must not disturb them
        drain_block();
        write_reg(REG_PEAK_THR, 10'd0);
        write_reg(REG_SAMPLE_THR, 10'd0);
        write_reg(REG_SPARE, 10'd1023);
        write_reg(REG_UNUSED, 10'd1023);
        random_traffic(150);

        // both at the top: no event can pass
        drain_block();
        write_reg(REG_PEAK_THR, 10'd1023);
        write_reg(REG_SAMPLE_THR, 10'd1023);
        random_traffic(100);

        // every event with a peak above zero passes, no sample contributes
        drain_block();
        write_reg(REG_PEAK_THR, 10'd0);
        random_traffic(100);

        // random thresholds at full rate, including an event that overfills
        // the sample store
        drain_block();
        write_reg(REG_PEAK_THR, ADC_W'($urandom_range(200)));
        write_reg(REG_SAMPLE_THR, ADC_W'($urandom_range(100)));
        steady = 1'b1;
        shaped_event(STORE_DEPTH + 4);
        random_traffic(100);
        steady = 1'b0;

        // back to the reset values
        drain_block();
        write_reg(REG_PEAK_THR, PEAK_THR_RST);
        write_reg(REG_SAMPLE_THR, SAMPLE_THR_RST);
        random_traffic(150);

        // let the last results arrive and watch for stray pulses
        drain_block();
        repeat (16)
            @(posedge clk);

        if (errors == 0 && owed_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
